// ===== hdl/assert_macros.svh =====
// assertion macros shared by the character lcd cursor writer
// no dependencies; each macro checks on the rising clock edge outside reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in every cycle
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/clrcw_pkg.sv =====
// types, constants and helpers for the character lcd cursor writer
// used by clrcw_cfg, clrcw_ctrl, clrcw_dp and the top level
package clrcw_pkg;

  localparam int unsigned ROW_COUNT_DEF = 2;
  localparam int unsigned COL_W         = 6;
  localparam int unsigned COL_MAX_W     = 5;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [COL_MAX_W-1:0] MAX_COL_LIMIT = 5'd20;
  localparam logic [7:0]           ROW0_BASE     = 8'h80;
  localparam logic [7:0]           ROW1_BASE     = 8'hC0;
  localparam logic [7:0]           SPACE_CHAR    = 8'h20;

  // request codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_MAX   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_AT_MAX = 1'd1;

  typedef struct packed {
    logic [1:0]       command;
    logic             row;
    logic [COL_W-1:0] column;
    logic [7:0]       char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [COL_MAX_W-1:0] column_max;
    logic                 clear_at_max;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SET,
    S_WR_ADDR,
    S_CLR_START,
    S_CLR_ADDR,
    S_CLR_SPACE,
    S_WR_DATA
  } state_t;

  typedef enum logic [2:0] {
    EM_ADDR_CUR,
    EM_ADDR_ZERO,
    EM_ADDR_REQ,
    EM_SPACE,
    EM_CHAR
  } emit_sel_t;

  typedef enum logic [1:0] {
    COL_HOLD,
    COL_LOAD,
    COL_ZERO,
    COL_INC
  } col_op_t;

  typedef struct packed {
    logic      load_req;
    logic      emit;
    emit_sel_t emit_sel;
    col_op_t   col_op;
    logic      last;
  } ctrl_t;

  typedef struct packed {
    logic       out_free;
    logic [1:0] req_cmd;
    logic       row_ok;
    logic       col_eq_max;
    logic       clear_at_max;
  } stat_t;

  function automatic logic [7:0] row_base(input logic row);
    return row ? ROW1_BASE : ROW0_BASE;
  endfunction

endpackage

// ===== hdl/clrcw_cfg.sv =====
// configuration registers: column maximum (saturating) and clear-at-max flag
// depends on clrcw_pkg
module clrcw_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [clrcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [clrcw_pkg::COL_MAX_W-1:0]     cfg_data,
  output clrcw_pkg::cfg_t                     cfg
);
  import clrcw_pkg::*;

  logic [COL_MAX_W-1:0] column_max_r, column_max_nxt;
  logic                 clear_at_max_r, clear_at_max_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    column_max_nxt   = column_max_r;
    clear_at_max_nxt = clear_at_max_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COLUMN_MAX: begin
          column_max_nxt = (cfg_data > MAX_COL_LIMIT) ? MAX_COL_LIMIT : cfg_data;
        end
        CFG_CLEAR_AT_MAX: begin
          clear_at_max_nxt = cfg_data[0];
        end
        default: begin
          column_max_nxt = column_max_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_max_r   <= '0;
      clear_at_max_r <= 1'b0;
    end else begin
      column_max_r   <= column_max_nxt;
      clear_at_max_r <= clear_at_max_nxt;
    end
  end

  assign cfg.column_max   = column_max_r;
  assign cfg.clear_at_max = clear_at_max_r;

endmodule

// ===== hdl/clrcw_ctrl.sv =====
// controller: sequences the lcd bytes of one request
// depends on clrcw_pkg; drives clrcw_dp through ctrl_t, reads stat_t
module clrcw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  clrcw_pkg::stat_t stat,
  output clrcw_pkg::ctrl_t ctrl
);
  import clrcw_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_stall      = 1'b1;
    ctrl.load_req = 1'b0;
    ctrl.emit     = 1'b0;
    ctrl.emit_sel = EM_ADDR_CUR;
    ctrl.col_op   = COL_HOLD;
    ctrl.last     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.load_req = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.row_ok) begin
          state_nxt = S_IDLE;
        end else begin
          unique case (stat.req_cmd)
            CMD_WRITE: state_nxt = S_WR_ADDR;
            CMD_SET:   state_nxt = S_SET;
            CMD_CLEAR: state_nxt = S_CLR_START;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_SET: begin
        if (stat.out_free) begin
          ctrl.emit     = 1'b1;
          ctrl.emit_sel = EM_ADDR_REQ;
          ctrl.col_op   = COL_LOAD;
          ctrl.last     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_WR_ADDR: begin
        if (stat.out_free) begin
          ctrl.emit     = 1'b1;
          ctrl.emit_sel = EM_ADDR_CUR;
          // row full: clear it before the character goes out
          state_nxt = (stat.clear_at_max && stat.col_eq_max) ? S_CLR_START : S_WR_DATA;
        end
      end
      S_CLR_START: begin
        if (stat.out_free) begin
          ctrl.emit     = 1'b1;
          ctrl.emit_sel = EM_ADDR_ZERO;
          ctrl.col_op   = COL_ZERO;
          state_nxt     = S_CLR_ADDR;
        end
      end
      S_CLR_ADDR: begin
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          if (stat.col_eq_max) begin
            // spaces done, home the cursor
            ctrl.emit_sel = EM_ADDR_ZERO;
            ctrl.col_op   = COL_ZERO;
            ctrl.last     = (stat.req_cmd == CMD_CLEAR);
            state_nxt     = (stat.req_cmd == CMD_CLEAR) ? S_IDLE : S_WR_DATA;
          end else begin
            ctrl.emit_sel = EM_ADDR_CUR;
            state_nxt     = S_CLR_SPACE;
          end
        end
      end
      S_CLR_SPACE: begin
        if (stat.out_free) begin
          ctrl.emit     = 1'b1;
          ctrl.emit_sel = EM_SPACE;
          ctrl.col_op   = COL_INC;
          state_nxt     = S_CLR_ADDR;
        end
      end
      S_WR_DATA: begin
        if (stat.out_free) begin
          ctrl.emit     = 1'b1;
          ctrl.emit_sel = EM_CHAR;
          ctrl.col_op   = COL_INC;
          ctrl.last     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/clrcw_dp.sv =====
// datapath: request register, per-row cursor columns and output byte register
// depends on clrcw_pkg; commanded by clrcw_ctrl through ctrl_t
module clrcw_dp #(
  parameter int unsigned ROW_COUNT = clrcw_pkg::ROW_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  clrcw_pkg::in_item_t  in_payload,
  output logic                 out_valid,
  input  logic                 out_stall,
  output clrcw_pkg::out_item_t out_payload,
  input  clrcw_pkg::cfg_t      cfg,
  input  clrcw_pkg::ctrl_t     ctrl,
  output clrcw_pkg::stat_t     stat
);
  import clrcw_pkg::*;

  in_item_t         req_r;
  logic [COL_W-1:0] cols_r   [ROW_COUNT];
  logic [COL_W-1:0] cols_nxt [ROW_COUNT];
  logic [COL_W-1:0] cur_col;
  logic [7:0]       base;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  always_ff @(posedge clk) begin
    if (ctrl.load_req) begin
      req_r <= in_payload;
    end
  end

  // cursor column of the addressed row
  always_comb begin
    cur_col = '0;
    for (int i = 0; i < int'(ROW_COUNT); i++) begin
      if (req_r.row == 1'(i)) begin
        cur_col = cols_r[i];
      end
    end
  end

  assign base = row_base(req_r.row);

  always_comb begin
    for (int i = 0; i < int'(ROW_COUNT); i++) begin
      cols_nxt[i] = cols_r[i];
      if (ctrl.emit && req_r.row == 1'(i)) begin
        case (ctrl.col_op)
          COL_LOAD: cols_nxt[i] = req_r.column;
          COL_ZERO: cols_nxt[i] = '0;
          COL_INC:  cols_nxt[i] = cols_r[i] + 1'b1;
          default:  cols_nxt[i] = cols_r[i];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(ROW_COUNT); i++) begin
        cols_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < int'(ROW_COUNT); i++) begin
        cols_r[i] <= cols_nxt[i];
      end
    end
  end

  always_comb begin
    out_item_nxt      = out_item_r;
    out_item_nxt.last = ctrl.last;
    unique case (ctrl.emit_sel)
      EM_ADDR_CUR: begin
        out_item_nxt.lcd_byte = base | {2'b00, cur_col};
        out_item_nxt.is_data  = 1'b0;
      end
      EM_ADDR_ZERO: begin
        out_item_nxt.lcd_byte = base;
        out_item_nxt.is_data  = 1'b0;
      end
      EM_ADDR_REQ: begin
        out_item_nxt.lcd_byte = base | {2'b00, req_r.column};
        out_item_nxt.is_data  = 1'b0;
      end
      EM_SPACE: begin
        out_item_nxt.lcd_byte = SPACE_CHAR;
        out_item_nxt.is_data  = 1'b1;
      end
      EM_CHAR: begin
        out_item_nxt.lcd_byte = req_r.char_code;
        out_item_nxt.is_data  = 1'b1;
      end
      default: begin
        out_item_nxt.lcd_byte = req_r.char_code;
        out_item_nxt.is_data  = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_item_r;

  assign stat.out_free     = !out_valid_r || !out_stall;
  assign stat.req_cmd      = req_r.command;
  assign stat.row_ok       = (int'(req_r.row) < int'(ROW_COUNT));
  assign stat.col_eq_max   = (cur_col == {1'b0, cfg.column_max});
  assign stat.clear_at_max = cfg.clear_at_max;

endmodule

// ===== hdl/char_lcd_row_cursor_writer.sv =====
// top level of the character lcd cursor writer: config regs, controller, datapath
// depends on clrcw_pkg, clrcw_cfg, clrcw_ctrl, clrcw_dp and assert_macros.svh
//
// Turns write-character, set-position and clear-row requests into a stream of
// lcd bytes (address commands and data), keeping one cursor column per row.
// One request is taken at a time: it is accepted in idle and decoded in the decode state, then
// one byte per cycle from the single output register while out_stall is low.
// Set-position emits one address byte, a plain write an address and the character,
// a clear-row the column-zero address, an address and space pair per column below
// column_max and the home address; a write that clears the row puts that in between.
// Codes that mean nothing and rows beyond ROW_COUNT are dropped after decode.
`include "assert_macros.svh"

module char_lcd_row_cursor_writer #(
  parameter int unsigned ROW_COUNT = clrcw_pkg::ROW_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  clrcw_pkg::in_item_t             in_payload,
  output logic                            out_valid,
  input  logic                            out_stall,
  output clrcw_pkg::out_item_t            out_payload,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [clrcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clrcw_pkg::COL_MAX_W-1:0] cfg_data
);
  import clrcw_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;
  stat_t stat;

  clrcw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  clrcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  clrcw_dp #(
    .ROW_COUNT (ROW_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .cfg         (cfg),
    .ctrl        (ctrl),
    .stat        (stat)
  );

  `ASSERT_IMPL(a_emit_free, clk, rst_n, ctrl.emit, stat.out_free, "byte emitted over a pending one")
  `ASSERT_ALWAYS(a_colmax_sat, clk, rst_n, cfg.column_max <= MAX_COL_LIMIT, "column_max above limit")
  `ASSERT_NEXT(a_last_idle, clk, rst_n, ctrl.emit && ctrl.last, !in_stall, "not idle after last byte")
  `ASSERT_IMPL(a_load_accept, clk, rst_n, ctrl.load_req, in_valid && !in_stall, "request loaded without accept")

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for char_lcd_row_cursor_writer: directed table, then random requests
// depends on clrcw_pkg and the char_lcd_row_cursor_writer rtl; predicts lcd bytes in place or takes typed ones
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import clrcw_pkg::*;

  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam logic [1:0] FROM_PREDICTOR = 2'd3;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         DRAIN_CYCLES   = 60;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         RAND_PHASES    = 4;
  localparam int         PHASE_ITEMS    = 19;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [COL_MAX_W-1:0] cfg_val;
    in_item_t             item;
    logic [1:0]           n_typed;
    out_item_t            t0;
    out_item_t            t1;
  } dir_step_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_payload = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_payload;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COL_MAX_W-1:0] cfg_data = '0;

  // predictor state
  logic [COL_W-1:0]     cur_col [2];
  logic [COL_MAX_W-1:0] col_limit = '0;
  logic                 clear_on_full = 1'b0;

  out_item_t lcd_exp_q [$];
  out_item_t new_bytes_q [$];
  dir_step_t dir_table [$];
  out_item_t want;
  int        err_count = 0;
  int        idle_cycles = 0;
  int        stall_left = 0;
  int        calm_left = 0;
  int        calm_items = 0;

  char_lcd_row_cursor_writer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  function automatic int pick_gap();
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [7:0] addr_byte(input logic row, input logic [COL_W-1:0] col);
    return (row ? ROW1_BASE : ROW0_BASE) | {2'b00, col};
  endfunction

  task automatic emit_byte(input logic [7:0] b, input logic is_data);
    out_item_t o;
    o.lcd_byte = b;
    o.is_data  = is_data;
    o.last     = 1'b0;
    new_bytes_q.push_back(o);
  endtask

  task automatic clear_row_bytes(input logic r);
    cur_col[r] = '0;
    emit_byte(addr_byte(r, cur_col[r]), 1'b0);
    while (cur_col[r] != {1'b0, col_limit}) begin
      emit_byte(addr_byte(r, cur_col[r]), 1'b0);
      emit_byte(SPACE_CHAR, 1'b1);
      cur_col[r] = cur_col[r] + 1'b1;
    end
    cur_col[r] = '0;
    emit_byte(addr_byte(r, cur_col[r]), 1'b0);
  endtask

  // fills new_bytes_q with the lcd bytes one request produces
  task automatic predict_lcd_bytes(input in_item_t req);
    out_item_t tail;
    logic      r;
    r = req.row;
    new_bytes_q.delete();
    case (req.command)
      CMD_WRITE: begin
        emit_byte(addr_byte(r, cur_col[r]), 1'b0);
        if (clear_on_full && cur_col[r] == {1'b0, col_limit}) clear_row_bytes(r);
        emit_byte(req.char_code, 1'b1);
        cur_col[r] = cur_col[r] + 1'b1;
      end
      CMD_SET: begin
        cur_col[r] = req.column;
        emit_byte(addr_byte(r, cur_col[r]), 1'b0);
      end
      CMD_CLEAR: clear_row_bytes(r);
      default: ;
    endcase
    if (new_bytes_q.size() > 0) begin
      tail = new_bytes_q[new_bytes_q.size()-1];
      tail.last = 1'b1;
      new_bytes_q[new_bytes_q.size()-1] = tail;
    end
  endtask

  task automatic send_request(input in_item_t req, input logic [1:0] n_typed,
                              input out_item_t t0, input out_item_t t1);
    int gap;
    if (calm_items > 0) begin
      calm_items--;
      gap = 0;
    end else if ($urandom_range(24) == 0) begin
      calm_items = $urandom_range(20, 10);
      gap = 0;
    end else if ($urandom_range(1) == 0) begin
      gap = 0;
    end else begin
      gap = pick_gap();
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_payload <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_lcd_bytes(req);
    if (n_typed == FROM_PREDICTOR) begin
      foreach (new_bytes_q[i]) lcd_exp_q.push_back(new_bytes_q[i]);
    end else begin
      if (n_typed >= 2'd1) lcd_exp_q.push_back(t0);
      if (n_typed == 2'd2) lcd_exp_q.push_back(t1);
    end
  endtask

  // only while idle: all bytes out, then a pause for requests that emit nothing
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [COL_MAX_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (lcd_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_COLUMN_MAX) col_limit = (val > MAX_COL_LIMIT) ? MAX_COL_LIMIT : val;
    else clear_on_full = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic dir_req(input logic [1:0] cmd, input logic row, input logic [COL_W-1:0] col,
                         input logic [7:0] ch, input logic [1:0] n,
                         input out_item_t t0, input out_item_t t1);
    dir_step_t s;
    s                = '0;
    s.item.command   = cmd;
    s.item.row       = row;
    s.item.column    = col;
    s.item.char_code = ch;
    s.n_typed        = n;
    s.t0             = t0;
    s.t1             = t1;
    dir_table.push_back(s);
  endtask

  task automatic dir_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [COL_MAX_W-1:0] val);
    dir_step_t s;
    s         = '0;
    s.is_cfg  = 1'b1;
    s.cfg_idx = idx;
    s.cfg_val = val;
    dir_table.push_back(s);
  endtask

  function automatic in_item_t rand_request();
    in_item_t req;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 55) req.command = CMD_WRITE;
    else if (pick < 75) req.command = CMD_SET;
    else if (pick < 92) req.command = CMD_CLEAR;
    else req.command = CMD_UNUSED;
    req.row = 1'($urandom_range(1));
    // half the positions land next to the full column so writes run into clears
    if ($urandom_range(1) == 0)
      req.column = COL_W'({1'b0, col_limit} + $urandom_range(2) - 1);
    else req.column = COL_W'($urandom_range(63));
    req.char_code = 8'($urandom_range(255));
    return req;
  endfunction

  always @(negedge clk) begin
    if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(59) == 0) begin
      calm_left = $urandom_range(100, 40);
      out_stall <= 1'b0;
    end else if ($urandom_range(3) == 0) begin
      stall_left = pick_gap() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (lcd_exp_q.size() == 0) begin
        flag_error($sformatf("unexpected lcd byte %h is_data %b last %b",
                             out_payload.lcd_byte, out_payload.is_data, out_payload.last));
      end else begin
        want = lcd_exp_q.pop_front();
        if (out_payload.lcd_byte !== want.lcd_byte)
          flag_error($sformatf("lcd_byte %h, expected %h", out_payload.lcd_byte, want.lcd_byte));
        if (out_payload.is_data !== want.is_data)
          flag_error($sformatf("is_data %b, expected %b (byte %h)",
                               out_payload.is_data, want.is_data, want.lcd_byte));
        if (out_payload.last !== want.last)
          flag_error($sformatf("last %b, expected %b (byte %h)",
                               out_payload.last, want.last, want.lcd_byte));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("char_lcd_row_cursor_writer verification failed");
      $finish;
    end
  end

  initial begin
    cur_col[0] = '0;
    cur_col[1] = '0;

    // reset values: full column 0, no clear
    dir_req(CMD_SET,    1'b0, 6'd63, 8'h00, 2'd1, {8'hBF, 1'b0, 1'b1}, '0);
    dir_req(CMD_WRITE,  1'b0, 6'd0,  8'hFF, 2'd2, {8'hBF, 1'b0, 1'b0}, {8'hFF, 1'b1, 1'b1});
    dir_req(CMD_SET,    1'b1, 6'd0,  8'h00, 2'd1, {8'hC0, 1'b0, 1'b1}, '0);
    dir_req(CMD_WRITE,  1'b1, 6'd63, 8'h00, 2'd2, {8'hC0, 1'b0, 1'b0}, {8'h00, 1'b1, 1'b1});
    // clear with full column 0: just two address commands
    dir_req(CMD_CLEAR,  1'b1, 6'd0,  8'h00, 2'd2, {8'hC0, 1'b0, 1'b0}, {8'hC0, 1'b0, 1'b1});
    dir_req(CMD_UNUSED, 1'b0, 6'd63, 8'hFF, 2'd0, '0, '0);
    dir_req(CMD_UNUSED, 1'b1, 6'd0,  8'h00, 2'd0, '0, '0);
    // 31 saturates to 20
    dir_cfg(CFG_COLUMN_MAX, 5'd31);
    dir_cfg(CFG_CLEAR_AT_MAX, 5'd1);
    dir_req(CMD_CLEAR,  1'b0, 6'd0,  8'h00, FROM_PREDICTOR, '0, '0);
    dir_req(CMD_SET,    1'b0, 6'd20, 8'h00, FROM_PREDICTOR, '0, '0);
    dir_req(CMD_WRITE,  1'b0, 6'd0,  8'h41, FROM_PREDICTOR, '0, '0);
    dir_req(CMD_WRITE,  1'b0, 6'd0,  8'h42, FROM_PREDICTOR, '0, '0);
    // past the full column no clear happens, counting wraps at 63
    dir_req(CMD_SET,    1'b1, 6'd21, 8'h00, FROM_PREDICTOR, '0, '0);
    dir_req(CMD_WRITE,  1'b1, 6'd0,  8'h7E, FROM_PREDICTOR, '0, '0);
    dir_req(CMD_SET,    1'b1, 6'd63, 8'h00, FROM_PREDICTOR, '0, '0);
    dir_req(CMD_WRITE,  1'b1, 6'd0,  8'h80, FROM_PREDICTOR, '0, '0);
    dir_req(CMD_WRITE,  1'b1, 6'd0,  8'h55, FROM_PREDICTOR, '0, '0);
    dir_cfg(CFG_COLUMN_MAX, 5'd0);
    dir_req(CMD_SET,    1'b0, 6'd0,  8'h00, FROM_PREDICTOR, '0, '0);
    dir_req(CMD_WRITE,  1'b0, 6'd0,  8'h5A, FROM_PREDICTOR, '0, '0);
    dir_req(CMD_CLEAR,  1'b0, 6'd0,  8'h00, FROM_PREDICTOR, '0, '0);
    dir_cfg(CFG_COLUMN_MAX, 5'd5);
    dir_cfg(CFG_CLEAR_AT_MAX, 5'd0);
    dir_req(CMD_SET,    1'b0, 6'd5,  8'h00, FROM_PREDICTOR, '0, '0);
    dir_req(CMD_WRITE,  1'b0, 6'd0,  8'h33, FROM_PREDICTOR, '0, '0);
    dir_cfg(CFG_COLUMN_MAX, 5'd21);
    dir_req(CMD_CLEAR,  1'b1, 6'd0,  8'h00, FROM_PREDICTOR, '0, '0);
    dir_cfg(CFG_COLUMN_MAX, 5'd20);
    dir_req(CMD_WRITE,  1'b1, 6'd0,  8'hA5, FROM_PREDICTOR, '0, '0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg)
        write_register(dir_table[i].cfg_idx, dir_table[i].cfg_val);
      else
        send_request(dir_table[i].item, dir_table[i].n_typed, dir_table[i].t0, dir_table[i].t1);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      // mostly short rows so that clears stay cheap
      if ($urandom_range(9) < 7) write_register(CFG_COLUMN_MAX, COL_MAX_W'($urandom_range(6)));
      else write_register(CFG_COLUMN_MAX, COL_MAX_W'($urandom_range(31)));
      write_register(CFG_CLEAR_AT_MAX, COL_MAX_W'($urandom_range(3) != 0));
      repeat (PHASE_ITEMS) send_request(rand_request(), FROM_PREDICTOR, '0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (lcd_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("char_lcd_row_cursor_writer verification clean");
    else
      $display("char_lcd_row_cursor_writer verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/clrcw_pkg.sv
hdl/clrcw_cfg.sv
hdl/clrcw_ctrl.sv
hdl/clrcw_dp.sv
hdl/char_lcd_row_cursor_writer.sv
verif/tb_top.sv
